### sv/sorted_id_list_set_ops_defines.svh
// Assertion macros for the sorted id list set operations block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_ID_LIST_SET_OPS_DEFINES_SVH
`define SORTED_ID_LIST_SET_OPS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SISOP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sisop assertion failed");

// antecedent implies consequent in the next cycle
`define SISOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sisop assertion failed");

`endif

### sv/sisop_pkg.sv
// Shared types and codes for the sorted id list set operations block.
// No dependencies.
package sisop_pkg;

	localparam int unsigned ID_W = 32;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD_A = 2'd1,
		CMD_LOAD_B = 2'd2,
		CMD_RUN    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OP_AND   = 2'd0,
		OP_OR    = 2'd1,
		OP_B_NOT = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// one merge step decision
	typedef struct packed {
		logic            emit;
		logic [ID_W-1:0] id;
		logic            adv_a;
		logic            adv_b;
		logic            done;
	} step_t;

endpackage

### sv/sisop_list_mem.sv
// Single list store: one write port, one read port, registered read data.
// Depends on sisop_pkg for the id width.
module sisop_list_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned IDX_W = 5
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [IDX_W-1:0]           waddr,
	input  logic [sisop_pkg::ID_W-1:0] wdata,
	input  logic [IDX_W-1:0]           raddr,
	output logic [sisop_pkg::ID_W-1:0] rdata
);

	logic [sisop_pkg::ID_W-1:0] mem [DEPTH];
	logic [sisop_pkg::ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/sisop_merge_step.sv
// Merge step decision: compares the heads of both lists for the chosen set operation.
// Depends on sisop_pkg for op codes and the step struct.
module sisop_merge_step (
	input  sisop_pkg::op_t              op,
	input  logic                        a_more,
	input  logic                        b_more,
	input  logic [sisop_pkg::ID_W-1:0]  a_head,
	input  logic [sisop_pkg::ID_W-1:0]  b_head,
	output sisop_pkg::step_t            step
);

	logic eq;
	logic a_lt;

	assign eq   = (a_head == b_head);
	assign a_lt = (a_head < b_head);

	always_comb begin
		step = '0;
		case (op)
			sisop_pkg::OP_AND: begin
				if (a_more && b_more) begin
					step.emit  = eq;
					step.id    = a_head;
					step.adv_a = eq || a_lt;
					step.adv_b = eq || !a_lt;
				end else begin
					step.done = 1'b1;
				end
			end
			sisop_pkg::OP_OR: begin
				if (a_more && b_more) begin
					step.emit  = 1'b1;
					step.id    = (eq || a_lt) ? a_head : b_head;
					step.adv_a = eq || a_lt;
					step.adv_b = eq || !a_lt;
				end else if (a_more) begin
					step.emit  = 1'b1;
					step.id    = a_head;
					step.adv_a = 1'b1;
				end else if (b_more) begin
					step.emit  = 1'b1;
					step.id    = b_head;
					step.adv_b = 1'b1;
				end else begin
					step.done = 1'b1;
				end
			end
			sisop_pkg::OP_B_NOT: begin
				if (!b_more) begin
					step.done = 1'b1;
				end else if (!a_more) begin
					step.emit  = 1'b1;
					step.id    = b_head;
					step.adv_b = 1'b1;
				end else begin
					// b below a: keep b; equal: drop both; a below b: skip a
					step.emit  = !eq && !a_lt;
					step.id    = b_head;
					step.adv_a = eq || a_lt;
					step.adv_b = !a_lt;
				end
			end
			default: begin
				step.done = 1'b1;
			end
		endcase
	end

endmodule

### sv/sorted_id_list_set_ops.sv
// Sorted id list set operations: two list memories merged by intersection, union or B minus A.
// A run makes one merge step per cycle unless the output stalls, set by the single read port
// of each list memory. An id is held in the pending register until the next id or the end of
// the run, then moves to the output register. Throughput: one load per cycle while idle.
// Reset: counts, overflow flag and control clear asynchronously; list contents are undefined.
// Depends on sisop_pkg, sisop_list_mem, sisop_merge_step and sorted_id_list_set_ops_defines.svh.
`include "sorted_id_list_set_ops_defines.svh"

module sorted_id_list_set_ops #(
	parameter int unsigned LIST_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] doc_id,
	input  logic [1:0]  set_op,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_id,
	output logic        result_valid,
	output logic        last_of_run,
	output logic        overflow_seen
);

	localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int unsigned ID_W  = sisop_pkg::ID_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t            st_q;
	logic [CNT_W-1:0]  cnt_a_q;
	logic [CNT_W-1:0]  cnt_b_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  i_nxt;
	logic [CNT_W-1:0]  j_nxt;
	sisop_pkg::op_t    op_q;
	logic              pend_vld_q;
	logic [ID_W-1:0]   pend_id_q;
	logic              out_vld_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_res_vld_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic              in_xfer;
	sisop_pkg::cmd_t   cmd;
	logic              load_a;
	logic              load_b;
	logic              a_full;
	logic              b_full;
	logic [ID_W-1:0]   a_head;
	logic [ID_W-1:0]   b_head;
	sisop_pkg::step_t  stp;
	logic              running;
	logic              out_free;
	logic              stall;
	logic              advance;
	logic              push_out;

	assign cmd      = sisop_pkg::cmd_t'(command);
	assign in_ready = (st_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign a_full   = (cnt_a_q == CNT_W'(LIST_DEPTH));
	assign b_full   = (cnt_b_q == CNT_W'(LIST_DEPTH));
	assign load_a   = in_xfer && (cmd == sisop_pkg::CMD_LOAD_A) && !a_full;
	assign load_b   = in_xfer && (cmd == sisop_pkg::CMD_LOAD_B) && !b_full;

	sisop_list_mem #(
		.DEPTH (LIST_DEPTH),
		.IDX_W (IDX_W)
	) u_list_a (
		.clk   (clk),
		.we    (load_a),
		.waddr (cnt_a_q[IDX_W-1:0]),
		.wdata (doc_id),
		.raddr (i_nxt[IDX_W-1:0]),
		.rdata (a_head)
	);

	sisop_list_mem #(
		.DEPTH (LIST_DEPTH),
		.IDX_W (IDX_W)
	) u_list_b (
		.clk   (clk),
		.we    (load_b),
		.waddr (cnt_b_q[IDX_W-1:0]),
		.wdata (doc_id),
		.raddr (j_nxt[IDX_W-1:0]),
		.rdata (b_head)
	);

	sisop_merge_step u_step (
		.op     (op_q),
		.a_more (i_q < cnt_a_q),
		.b_more (j_q < cnt_b_q),
		.a_head (a_head),
		.b_head (b_head),
		.step   (stp)
	);

	// loads and runs are serialized by in_ready, so no read/write overlap on a list
	assign running  = (st_q == ST_RUN);
	assign out_free = !out_vld_q || out_ready;
	assign stall    = running && !out_free && ((stp.emit && pend_vld_q) || stp.done);
	assign advance  = running && !stall && !stp.done;
	assign push_out = running && !stall && ((stp.emit && pend_vld_q) || stp.done);

	always_comb begin
		i_nxt = i_q;
		j_nxt = j_q;
		if (!running) begin
			i_nxt = '0;
			j_nxt = '0;
		end else if (advance) begin
			if (stp.adv_a) begin
				i_nxt = i_q + CNT_W'(1);
			end
			if (stp.adv_b) begin
				j_nxt = j_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			cnt_a_q    <= '0;
			cnt_b_q    <= '0;
			ovf_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			i_q <= i_nxt;
			j_q <= j_nxt;
			if (in_xfer) begin
				case (cmd)
					sisop_pkg::CMD_CLEAR: begin
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						ovf_q   <= 1'b0;
					end
					sisop_pkg::CMD_LOAD_A: begin
						if (a_full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_a_q <= cnt_a_q + CNT_W'(1);
						end
					end
					sisop_pkg::CMD_LOAD_B: begin
						if (b_full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_b_q <= cnt_b_q + CNT_W'(1);
						end
					end
					sisop_pkg::CMD_RUN: begin
						st_q <= ST_RUN;
					end
					default: begin
						st_q <= ST_IDLE;
					end
				endcase
			end
			if (advance && stp.emit) begin
				pend_vld_q <= 1'b1;
			end else if (running && stp.done && !stall) begin
				pend_vld_q <= 1'b0;
				st_q       <= ST_IDLE;
			end
			if (push_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (cmd == sisop_pkg::CMD_RUN)) begin
			op_q <= sisop_pkg::op_t'(set_op);
		end
		if (advance && stp.emit) begin
			pend_id_q <= stp.id;
		end
		if (push_out) begin
			out_id_q      <= pend_vld_q ? pend_id_q : '0;
			out_res_vld_q <= pend_vld_q;
			out_last_q    <= stp.done;
			out_ovf_q     <= ovf_q;
		end
	end

	assign out_valid     = out_vld_q;
	assign result_id     = out_id_q;
	assign result_valid  = out_res_vld_q;
	assign last_of_run   = out_last_q;
	assign overflow_seen = out_ovf_q;

	`SISOP_ASSERT_NOW(a_idle_no_pending, clk, arst_n, st_q == ST_IDLE, !pend_vld_q)
	`SISOP_ASSERT_NOW(a_walk_in_range, clk, arst_n, running,
		(i_q <= cnt_a_q) && (j_q <= cnt_b_q))
	`SISOP_ASSERT_NEXT(a_counts_hold_in_run, clk, arst_n, running,
		$stable(cnt_a_q) && $stable(cnt_b_q))
	`SISOP_ASSERT_NOW(a_empty_is_last, clk, arst_n, out_vld_q && !out_res_vld_q, out_last_q)

endmodule

### bench/tb_top.sv
// Testbench for sorted_id_list_set_ops: loads id lists, runs intersection, union and
// B minus A, and checks every result transfer against an in-bench merge predictor.
// Depends on sisop_pkg and the sorted_id_list_set_ops RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned LIST_DEPTH   = 32;
	localparam int unsigned RANDOM_ITEMS = 70;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned TAIL_CYCLES  = 100;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	typedef enum int {SET_NARROW, SET_WIDE, SET_TOP, SET_UNSORTED} id_style_t;

	typedef struct packed {
		logic [31:0] id;
		logic        has_id;
		logic        last;
		logic        ovf;
	} id_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = sisop_pkg::CMD_CLEAR;
	logic [31:0] doc_id = '0;
	logic [1:0]  set_op = sisop_pkg::OP_AND;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result_id;
	logic        result_valid;
	logic        last_of_run;
	logic        overflow_seen;

	// predictor state
	logic [31:0] ids_a [LIST_DEPTH];
	logic [31:0] ids_b [LIST_DEPTH];
	logic [5:0]  count_a = '0;
	logic [5:0]  count_b = '0;
	logic        dropped_load = 1'b0;
	id_beat_t    pending [$];

	int unsigned sent_items = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          idle_on = 1'b1;
	bit          stall_on = 1'b1;
	int unsigned hold_reqs = 0;
	int unsigned holds_started = 0;
	int unsigned hold_left = 0;

	sorted_id_list_set_ops #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.doc_id       (doc_id),
		.set_op       (set_op),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_id    (result_id),
		.result_valid (result_valid),
		.last_of_run  (last_of_run),
		.overflow_seen(overflow_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_started != hold_reqs) begin
			out_ready     <= 1'b0;
			hold_left     <= HOLD_CYCLES;
			holds_started <= holds_started + 1;
		end else begin
			out_ready <= !(stall_on && $urandom_range(99) < 19);
		end
	end

	function automatic void report_mismatch(string what, id_beat_t want, id_beat_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s: exp id=%h v=%b l=%b o=%b, got id=%h v=%b l=%b o=%b",
				what, want.id, want.has_id, want.last, want.ovf,
				got.id, got.has_id, got.last, got.ovf);
	endfunction

	always @(posedge clk) begin
		id_beat_t got;
		id_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {result_id, result_valid, last_of_run, overflow_seen};
			if (pending.size() == 0) begin
				report_mismatch("unexpected transfer", '0, got);
			end else begin
				want = pending.pop_front();
				if (got !== want)
					report_mismatch("result", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void apply_command(sisop_pkg::cmd_t cmd, logic [31:0] id,
		sisop_pkg::op_t op);
		logic [31:0] ids_out [$];
		int unsigned i;
		int unsigned j;
		i = 0;
		j = 0;
		case (cmd)
			sisop_pkg::CMD_CLEAR: begin
				count_a = '0;
				count_b = '0;
				dropped_load = 1'b0;
			end
			sisop_pkg::CMD_LOAD_A: begin
				if (count_a < LIST_DEPTH) begin
					ids_a[count_a] = id;
					count_a++;
				end else begin
					dropped_load = 1'b1;
				end
			end
			sisop_pkg::CMD_LOAD_B: begin
				if (count_b < LIST_DEPTH) begin
					ids_b[count_b] = id;
					count_b++;
				end else begin
					dropped_load = 1'b1;
				end
			end
			default: begin
				case (op)
					sisop_pkg::OP_AND: begin
						while (i < count_a && j < count_b) begin
							if (ids_a[i] == ids_b[j]) begin
								ids_out.push_back(ids_a[i]);
								i++;
								j++;
							end else if (ids_a[i] < ids_b[j]) begin
								i++;
							end else begin
								j++;
							end
						end
					end
					sisop_pkg::OP_OR: begin
						while (i < count_a && j < count_b) begin
							if (ids_a[i] == ids_b[j]) begin
								ids_out.push_back(ids_a[i]);
								i++;
								j++;
							end else if (ids_a[i] < ids_b[j]) begin
								ids_out.push_back(ids_a[i]);
								i++;
							end else begin
								ids_out.push_back(ids_b[j]);
								j++;
							end
						end
						while (i < count_a) begin
							ids_out.push_back(ids_a[i]);
							i++;
						end
						while (j < count_b) begin
							ids_out.push_back(ids_b[j]);
							j++;
						end
					end
					sisop_pkg::OP_B_NOT: begin
						while (j < count_b) begin
							if (i >= count_a || ids_b[j] < ids_a[i]) begin
								ids_out.push_back(ids_b[j]);
								j++;
							end else if (ids_b[j] == ids_a[i]) begin
								i++;
								j++;
							end else begin
								i++;
							end
						end
					end
					default: ;
				endcase
				if (ids_out.size() == 0)
					pending.push_back({32'h0, 1'b0, 1'b1, dropped_load});
				foreach (ids_out[k])
					pending.push_back({ids_out[k], 1'b1, k == ids_out.size() - 1, dropped_load});
			end
		endcase
	endfunction

	task automatic send_item(sisop_pkg::cmd_t cmd, logic [31:0] id, sisop_pkg::op_t op);
		while (idle_on && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		doc_id <= id;
		set_op <= op;
		do @(posedge clk); while (!in_ready);
		apply_command(cmd, id, op);
		sent_items++;
	endtask

	// clear, load a shared pool (ascending unless the style is unsorted) split over A, B or both, then run
	task automatic send_sets(int unsigned pool_max, id_style_t style);
		logic [32:0] cur;
		int unsigned pool_len;
		int unsigned member;
		send_item(sisop_pkg::CMD_CLEAR, $urandom, sisop_pkg::op_t'($urandom_range(3)));
		pool_len = $urandom_range(pool_max);
		case (style)
			SET_NARROW: cur = 33'($urandom_range(4));
			SET_WIDE:   cur = 33'($urandom >> $urandom_range(31));
			SET_TOP:    cur = 33'h0_FFFF_FFFF - 33'($urandom_range(150));
			default:    cur = '0;
		endcase
		for (int k = 0; k < pool_len && cur <= 33'h0_FFFF_FFFF; k++) begin
			member = $urandom_range(2);
			if (style == SET_UNSORTED)
				cur = 33'($urandom_range(20));
			if (member != 1)
				send_item(sisop_pkg::CMD_LOAD_A, cur[31:0], sisop_pkg::op_t'($urandom_range(3)));
			if (member != 0)
				send_item(sisop_pkg::CMD_LOAD_B, cur[31:0], sisop_pkg::op_t'($urandom_range(3)));
			case (style)
				SET_NARROW: cur += 33'($urandom_range(1, 3));
				SET_WIDE:   cur += 33'($urandom_range(1, 32'h0800_0000));
				SET_TOP:    cur += 33'($urandom_range(1, 4));
				default: ;
			endcase
		end
		repeat ($urandom_range(1, 3))
			send_item(sisop_pkg::CMD_RUN, $urandom,
				$urandom_range(9) == 0 ? sisop_pkg::OP_NONE :
					sisop_pkg::op_t'($urandom_range(2)));
		// append to a list after a run, without a clear
		if ($urandom_range(3) == 0 && cur <= 33'h0_FFFF_FFFF) begin
			send_item($urandom_range(1) ? sisop_pkg::CMD_LOAD_A : sisop_pkg::CMD_LOAD_B,
				cur[31:0], sisop_pkg::OP_AND);
			send_item(sisop_pkg::CMD_RUN, $urandom, sisop_pkg::op_t'($urandom_range(2)));
		end
	endtask

	task automatic test_directed();
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_LOAD_A, 32'h0, sisop_pkg::OP_NONE);
		send_item(sisop_pkg::CMD_LOAD_A, 32'd5, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_LOAD_A, 32'hFFFF_FFFF, sisop_pkg::OP_OR);
		send_item(sisop_pkg::CMD_LOAD_B, 32'd5, sisop_pkg::OP_B_NOT);
		send_item(sisop_pkg::CMD_LOAD_B, 32'd7, sisop_pkg::OP_NONE);
		send_item(sisop_pkg::CMD_LOAD_B, 32'hFFFF_FFFF, sisop_pkg::OP_AND);
		for (int k = 0; k < 4; k++)
			send_item(sisop_pkg::CMD_RUN, 32'hFFFF_FFFF, sisop_pkg::op_t'(k));
		// A goes out of order
		send_item(sisop_pkg::CMD_LOAD_A, 32'd3, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_OR);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_B_NOT);
		send_item(sisop_pkg::CMD_CLEAR, 32'hA5A5_5A5A, sisop_pkg::OP_NONE);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_OR);
		send_item(sisop_pkg::CMD_LOAD_A, 32'd9, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_B_NOT);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_OR);
		send_item(sisop_pkg::CMD_LOAD_B, 32'd9, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_RUN, 32'h5A5A_A5A5, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_B_NOT);
		send_item(sisop_pkg::CMD_CLEAR, 32'h0, sisop_pkg::OP_AND);
	endtask

	task automatic test_overflow();
		for (int k = 0; k < LIST_DEPTH + 2; k++) begin
			send_item(sisop_pkg::CMD_LOAD_A, k * 3, sisop_pkg::OP_AND);
			if (k <= LIST_DEPTH)
				send_item(sisop_pkg::CMD_LOAD_B, k * 2, sisop_pkg::OP_OR);
		end
		for (int k = 0; k < 4; k++)
			send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::op_t'(k));
		send_item(sisop_pkg::CMD_CLEAR, 32'h0, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_OR);
		for (int k = 0; k <= LIST_DEPTH; k++)
			send_item(sisop_pkg::CMD_LOAD_B, 32'hFFFF_FF00 + k, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_B_NOT);
		send_item(sisop_pkg::CMD_CLEAR, 32'h0, sisop_pkg::OP_AND);
	endtask

	task automatic test_backpressure();
		send_item(sisop_pkg::CMD_CLEAR, 32'h0, sisop_pkg::OP_AND);
		for (int k = 0; k < LIST_DEPTH; k++) begin
			send_item(sisop_pkg::CMD_LOAD_A, 2 * k, sisop_pkg::OP_AND);
			send_item(sisop_pkg::CMD_LOAD_B, 2 * k + 1, sisop_pkg::OP_AND);
		end
		hold_reqs <= hold_reqs + 1;
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_OR);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_B_NOT);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_OR);
		send_item(sisop_pkg::CMD_CLEAR, 32'h0, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_LOAD_A, 32'd1, sisop_pkg::OP_AND);
		send_item(sisop_pkg::CMD_RUN, 32'h0, sisop_pkg::OP_OR);
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		stall_on = 1'b0;
		repeat (8)
			send_sets(14, $urandom_range(1) ? SET_NARROW : SET_WIDE);
		idle_on = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_random();
		int unsigned target;
		int unsigned pick;
		target = sent_items + RANDOM_ITEMS;
		while (sent_items < target) begin
			pick = $urandom_range(99);
			if (pick < 45)
				send_sets(10, SET_NARROW);
			else if (pick < 65)
				send_sets(12, SET_WIDE);
			else if (pick < 72)
				send_sets(8, SET_TOP);
			else if (pick < 80)
				send_sets(60, $urandom_range(1) ? SET_NARROW : SET_WIDE);
			else if (pick < 90)
				send_sets(10, SET_UNSORTED);
			else
				repeat ($urandom_range(1, 4))
					send_item(sisop_pkg::cmd_t'($urandom_range(3)), $urandom,
						sisop_pkg::op_t'($urandom_range(3)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_backpressure();
		test_no_idle();
		test_random();
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
